FILE: hdl/sebd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sebd_pkg;

    // Fixed field widths of the data words.
    localparam int BIN_WIDTH    = 16;
    localparam int ENERGY_BITS  = BIN_WIDTH + 9;
    localparam int TIME_WIDTH   = 16;
    localparam int LEVEL_WIDTH  = 16;
    localparam int OUT_EN_WIDTH = 25;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BEAT_RATIO = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FADE_OUT   = 2'd1;

    localparam logic [CFG_DATA_WIDTH-1:0] BEAT_RATIO_RESET = 16'd358;
    localparam logic [CFG_DATA_WIDTH-1:0] FADE_OUT_RESET   = 16'd1024;

    // 1.0 in Q1.15, as an energy value and as an intensity value.
    localparam logic [ENERGY_BITS-1:0] ENERGY_ONE = 25'd32768;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_ONE  = 16'd32768;

    // Input word: one spectrum bin.
    typedef struct packed {
        logic [BIN_WIDTH-1:0]  bin_magnitude;
        logic                  last_bin;
        logic [TIME_WIDTH-1:0] frame_time;
    } t_in_word;

    // Output word: one frame result.
    typedef struct packed {
        logic [LEVEL_WIDTH-1:0]  beat_level;
        logic                    beat_detected;
        logic [OUT_EN_WIDTH-1:0] frame_energy;
    } t_out_word;

endpackage

`default_nettype wire

FILE: hdl/sebd_history_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sebd_history_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port; a read at the address
    // being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/spectral_energy_beat_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one bin word accepted per cycle unless the output stalls the pipeline;
// frames may be a single bin long. A frame result passes through the accumulate
// stage, the multiply and history update stage, then the compare and decay stage.
// Reset (synchronous, active low) restores the control registers, the history state and
// the fill count at once; the history memory itself needs no clearing pass.

module spectral_energy_beat_detector #(
    parameter int HISTORY_DEPTH = 512
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire sebd_pkg::t_in_word                   i_in_word,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output sebd_pkg::t_out_word                       o_out_word,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sebd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [sebd_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int EW     = sebd_pkg::ENERGY_BITS;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = EW + PTR_W;
    localparam int PROD_W = EW + FILL_W;
    localparam int LHS_W  = PROD_W + 8;
    localparam int RHS_W  = sebd_pkg::CFG_DATA_WIDTH + SUM_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int DECP_W = sebd_pkg::CFG_DATA_WIDTH + sebd_pkg::TIME_WIDTH;
    localparam int DEC_W  = DECP_W - 9;

    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_SLOT  = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_RESET  =
        SUM_W'(HISTORY_DEPTH) * SUM_W'(sebd_pkg::ENERGY_ONE);

    // Configuration registers.
    logic [sebd_pkg::CFG_DATA_WIDTH-1:0] r_beat_ratio;
    logic [sebd_pkg::CFG_DATA_WIDTH-1:0] r_fade_out;

    // Stage handshake.
    logic w_adv_a, w_adv_b, w_adv_c;
    logic w_in_fire, w_a_to_b, w_b_to_c;

    // Accumulate stage.
    logic [EW-1:0]                   r_acc;
    logic                            r_a_valid;
    logic [EW-1:0]                   r_a_energy;
    logic [sebd_pkg::TIME_WIDTH-1:0] r_a_time;
    logic [EW:0]                     w_acc_sum;
    logic [EW-1:0]                   w_energy;

    // History state.
    logic [SUM_W-1:0]  r_sum;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_lap;
    logic              r_fwd;
    logic [EW-1:0]     r_fwd_data;
    logic [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0] n_fill;
    logic [PTR_W-1:0]  n_ptr;
    logic              n_lap;
    logic              w_filling;
    logic              n_filling;
    logic [FILL_W-1:0] w_fill_m1;
    logic [FILL_W-1:0] n_fill_m1;
    logic [PTR_W-1:0]  w_slot;
    logic [PTR_W-1:0]  w_rd_addr;
    logic              w_old_default;
    logic [EW-1:0]     w_old;
    logic [EW-1:0]     w_rd_data;

    // Multiply stage.
    logic              r_b_valid;
    logic [LHS_W-1:0]  r_b_lhs;
    logic [RHS_W-1:0]  r_b_rhs;
    logic [DEC_W-1:0]  r_b_dec;
    logic [EW-1:0]     r_b_energy;
    logic [PROD_W-1:0] w_lhs_prod;
    logic [DECP_W-1:0] w_dec_prod;

    // Compare and decay stage.
    logic [sebd_pkg::LEVEL_WIDTH-1:0] r_level;
    logic [sebd_pkg::LEVEL_WIDTH-1:0] n_level;
    logic                             w_beat;
    logic                             r_out_valid;
    sebd_pkg::t_out_word              r_out_word;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_ratio <= sebd_pkg::BEAT_RATIO_RESET;
            r_fade_out   <= sebd_pkg::FADE_OUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sebd_pkg::REG_BEAT_RATIO: r_beat_ratio <= i_cfg_data;
                sebd_pkg::REG_FADE_OUT:   r_fade_out   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage moves on when the one after it is empty or moving too.
    assign w_adv_c    = !r_out_valid || i_out_ready;
    assign w_adv_b    = !r_b_valid || w_adv_c;
    assign w_adv_a    = !r_a_valid || w_adv_b;
    assign o_in_ready = w_adv_a;
    assign w_in_fire  = i_in_valid && w_adv_a;
    assign w_a_to_b   = r_a_valid && w_adv_b;
    assign w_b_to_c   = r_b_valid && w_adv_c;

    // Saturating frame accumulation.
    assign w_acc_sum = {1'b0, r_acc} + (EW + 1)'(i_in_word.bin_magnitude);
    assign w_energy  = w_acc_sum[EW] ? {EW{1'b1}} : w_acc_sum[EW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_a_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_acc     <= i_in_word.last_bin ? '0 : w_energy;
            r_a_valid <= i_in_word.last_bin;
        end else if (w_adv_b) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_a_energy <= w_energy;
            r_a_time   <= i_in_word.frame_time;
        end
    end

    // Slot selection: while filling, slot fill_count-1, then ring order.
    // Slots never written hold 1.0; the last slot is first written on the
    // opening lap of the ring.
    assign w_filling     = r_fill < DEPTH_FILL;
    assign w_fill_m1     = r_fill - FILL_W'(1);
    assign w_slot        = w_filling ? w_fill_m1[PTR_W-1:0] : r_ptr;
    assign w_old_default = w_filling || (!r_lap && (r_ptr == LAST_SLOT));
    assign w_old         = w_old_default ? sebd_pkg::ENERGY_ONE
                         : (r_fwd ? r_fwd_data : w_rd_data);

    // Next history state once a frame leaves the accumulate stage.
    always_comb begin
        n_fill = r_fill;
        n_ptr  = r_ptr;
        n_lap  = r_lap;
        n_sum  = r_sum;
        if (w_a_to_b) begin
            n_sum = r_sum - SUM_W'(w_old) + SUM_W'(r_a_energy);
            if (w_filling) begin
                n_fill = r_fill + FILL_W'(1);
            end else if (r_ptr == LAST_SLOT) begin
                n_ptr = '0;
                n_lap = 1'b1;
            end else begin
                n_ptr = r_ptr + PTR_W'(1);
            end
        end
    end

    // Prefetch the slot the next frame will replace.
    assign n_filling = n_fill < DEPTH_FILL;
    assign n_fill_m1 = n_fill - FILL_W'(1);
    assign w_rd_addr = n_filling ? n_fill_m1[PTR_W-1:0] : n_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= SUM_RESET;
            r_fill <= FILL_W'(1);
            r_ptr  <= '0;
            r_lap  <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
            r_ptr  <= n_ptr;
            r_lap  <= n_lap;
            r_fwd  <= w_a_to_b && (w_slot == w_rd_addr);
        end
    end

    // Forwarded word for a prefetch of the slot being written.
    always_ff @(posedge i_clk) begin
        r_fwd_data <= r_a_energy;
    end

    sebd_history_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (EW)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (w_a_to_b),
        .i_wr_addr (w_slot),
        .i_wr_data (r_a_energy),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Threshold products and the decay step, from the state before this frame.
    assign w_lhs_prod = PROD_W'(r_a_energy) * PROD_W'(r_fill);
    assign w_dec_prod = DECP_W'(r_fade_out) * DECP_W'(r_a_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_to_b) begin
            r_b_lhs    <= {w_lhs_prod, 8'd0};
            r_b_rhs    <= RHS_W'(r_beat_ratio) * RHS_W'(r_sum);
            r_b_dec    <= w_dec_prod[DECP_W-1:9];
            r_b_energy <= r_a_energy;
        end
    end

    // Beat decision and intensity decay with a floor at zero.
    assign w_beat = CMP_W'(r_b_lhs) > CMP_W'(r_b_rhs);

    always_comb begin
        n_level = r_level;
        if (w_beat) begin
            n_level = sebd_pkg::LEVEL_ONE;
        end else if (r_level != '0) begin
            if (r_b_dec >= DEC_W'(r_level)) begin
                n_level = '0;
            end else begin
                n_level = r_level - r_b_dec[sebd_pkg::LEVEL_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_b_to_c) begin
            r_level     <= n_level;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_to_c) begin
            r_out_word.beat_level    <= n_level;
            r_out_word.beat_detected <= w_beat;
            r_out_word.frame_energy  <= r_b_energy[sebd_pkg::OUT_EN_WIDTH-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire
